// ===== rtl/bc4_bc5_block_encoder_top_defines.svh =====
// Assertion macros used by the RTL front end.
`ifndef BC4_BC5_BLOCK_ENCODER_TOP_DEFINES_SVH
`define BC4_BC5_BLOCK_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define BCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bce_pkg.sv =====
package bce_pkg;

	localparam int unsigned TEXELS = 16;
	localparam int unsigned POS_W  = 4;
	localparam int unsigned ADDR_W = POS_W + 1;

	// n/7 and n/5 for n < 2048 by reciprocal multiply
	localparam logic [11:0] RECIP7 = 12'd2341;
	localparam logic [11:0] RECIP5 = 12'd3277;
	localparam int unsigned RECIP_SHIFT = 14;

	localparam logic REG_MODE = 1'b0;

	typedef struct packed {
		logic [7:0] red_sample;
		logic [7:0] green_sample;
	} texel_t;

	typedef struct packed {
		logic [7:0]  endpoint_high;
		logic [7:0]  endpoint_low;
		logic [47:0] index_bits;
		logic        channel_tag;
		logic        last_of_block;
	} block_t;

	typedef struct packed {
		logic       bank;
		logic [7:0] red_max;
		logic [7:0] red_min;
		logic [7:0] green_max;
		logic [7:0] green_min;
		logic       mode;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       data;
	} wr_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAL,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} back_state_t;

endpackage

// ===== rtl/bce_fifo.sv =====
module bce_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bce_pkg::job_t push_data,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output bce_pkg::job_t head
);
	import bce_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

endmodule

// ===== rtl/bce_front.sv =====
`include "bc4_bc5_block_encoder_top_defines.svh"

module bce_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            texel_valid,
	output logic            texel_stall,
	input  bce_pkg::texel_t texel,
	input  logic            mode,
	input  logic            fifo_full,
	input  logic            fifo_not_empty,
	input  bce_pkg::rel_t   rel,
	output logic            push,
	output bce_pkg::job_t   push_data,
	output bce_pkg::wr_t    wr
);
	import bce_pkg::*;

	logic [POS_W-1:0] count_q;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic [1:0]       busy_n;
	logic [7:0]       rmin_q, rmax_q, gmin_q, gmax_q;
	logic [7:0]       rmin_n, rmax_n, gmin_n, gmax_n;
	logic             accept;
	logic             blk_end;

	assign texel_stall = busy_q[bank_q] | fifo_full;
	assign accept      = texel_valid & ~texel_stall;
	assign blk_end     = accept & (count_q == POS_W'(TEXELS - 1));

	assign rmin_n = (texel.red_sample   < rmin_q) ? texel.red_sample   : rmin_q;
	assign rmax_n = (texel.red_sample   > rmax_q) ? texel.red_sample   : rmax_q;
	assign gmin_n = (texel.green_sample < gmin_q) ? texel.green_sample : gmin_q;
	assign gmax_n = (texel.green_sample > gmax_q) ? texel.green_sample : gmax_q;

	assign wr.en   = accept;
	assign wr.addr = {bank_q, count_q};
	assign wr.data = {texel.green_sample, texel.red_sample};

	assign push                = blk_end;
	assign push_data.bank      = bank_q;
	assign push_data.red_max   = rmax_n;
	assign push_data.red_min   = rmin_n;
	assign push_data.green_max = gmax_n;
	assign push_data.green_min = gmin_n;
	assign push_data.mode      = mode;

	always_comb begin
		busy_n = busy_q;
		if (rel.valid) begin
			busy_n[rel.bank] = 1'b0;
		end
		if (blk_end) begin
			busy_n[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q  <= 1'b0;
			busy_q  <= 2'b00;
			rmin_q  <= 8'hff;
			rmax_q  <= 8'h00;
			gmin_q  <= 8'hff;
			gmax_q  <= 8'h00;
		end else begin
			busy_q <= busy_n;
			if (blk_end) begin
				count_q <= '0;
				bank_q  <= ~bank_q;
				rmin_q  <= 8'hff;
				rmax_q  <= 8'h00;
				gmin_q  <= 8'hff;
				gmax_q  <= 8'h00;
			end else if (accept) begin
				count_q <= count_q + POS_W'(1);
				rmin_q  <= rmin_n;
				rmax_q  <= rmax_n;
				gmin_q  <= gmin_n;
				gmax_q  <= gmax_n;
			end
		end
	end

	`BCE_ASSERT_IMP(a_push_room, push, !fifo_full, "block pushed into full queue")
	`BCE_ASSERT_IMP(a_rel_busy, rel.valid, busy_q[rel.bank], "release of idle bank")
	`BCE_ASSERT_IMP(a_busy_queued, busy_q != 2'b00, fifo_not_empty, "busy bank without job")
	`BCE_ASSERT_NXT(a_push_marks, push, busy_q[$past(bank_q)], "bank not marked busy")

endmodule

// ===== rtl/bce_back.sv =====
module bce_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bce_pkg::wr_t    wr,
	input  logic            job_valid,
	input  bce_pkg::job_t   job,
	output logic            pop,
	output bce_pkg::rel_t   rel,
	output logic            block_valid,
	input  logic            block_stall,
	output bce_pkg::block_t block
);
	import bce_pkg::*;

	function automatic logic [7:0] pal_entry(input logic [7:0] hi, input logic [7:0] lo,
	                                         input int unsigned i, input logic seven);
		logic [10:0] num;
		logic [22:0] prod;
		begin
			if (seven) begin
				num  = 11'(7 - i) * 11'(hi) + 11'(i) * 11'(lo);
				prod = 23'(num) * 23'(RECIP7);
			end else begin
				num  = 11'(5 - i) * 11'(hi) + 11'(i) * 11'(lo);
				prod = 23'(num) * 23'(RECIP5);
			end
			pal_entry = prod[RECIP_SHIFT +: 8];
		end
	endfunction

	logic [15:0]      mem_q [2 * TEXELS];
	back_state_t      state_q, state_n;
	logic             chan_q;
	logic [POS_W-1:0] rd_cnt_q;
	logic [7:0]       pal_q [8];
	logic [7:0]       pal_n [8];
	logic [7:0]       hi_q, lo_q, hi_n, lo_n;
	logic             rd_v_s1;
	logic [15:0]      rd_data_s1;
	logic [47:0]      acc_q;
	logic             blk_valid_q;
	block_t           blk_q;
	logic             can_load, load, rd_en, last;
	logic [7:0]       smp;
	logic [7:0]       err;
	logic [7:0]       best_err;
	logic [2:0]       best;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[{job.bank, rd_cnt_q}];
		end
	end

	assign hi_n = chan_q ? job.green_max : job.red_max;
	assign lo_n = chan_q ? job.green_min : job.red_min;

	always_comb begin
		pal_n[0] = hi_n;
		pal_n[1] = lo_n;
		if (hi_n > lo_n) begin
			for (int unsigned i = 1; i <= 6; i++) begin
				pal_n[i + 1] = pal_entry(hi_n, lo_n, i, 1'b1);
			end
		end else begin
			for (int unsigned i = 1; i <= 4; i++) begin
				pal_n[i + 1] = pal_entry(hi_n, lo_n, i, 1'b0);
			end
			pal_n[6] = 8'd0;
			pal_n[7] = 8'd255;
		end
	end

	// nearest entry, first one wins ties
	assign smp = chan_q ? rd_data_s1[15:8] : rd_data_s1[7:0];
	always_comb begin
		best     = 3'd0;
		best_err = (smp > pal_q[0]) ? smp - pal_q[0] : pal_q[0] - smp;
		err      = best_err;
		for (int unsigned p = 1; p < 8; p++) begin
			err = (smp > pal_q[p]) ? smp - pal_q[p] : pal_q[p] - smp;
			if (err < best_err) begin
				best     = 3'(p);
				best_err = err;
			end
		end
	end

	assign can_load = ~blk_valid_q | ~block_stall;
	assign last     = ~(~chan_q & job.mode);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_n = ST_PAL;
				end
			end
			ST_PAL:   state_n = ST_SCAN;
			ST_SCAN: begin
				if (rd_cnt_q == POS_W'(TEXELS - 1)) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: state_n = ST_OUT;
			ST_OUT: begin
				if (can_load) begin
					state_n = last ? ST_IDLE : ST_PAL;
				end
			end
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en    = (state_q == ST_SCAN);
		load     = (state_q == ST_OUT) & can_load;
		pop      = load & last;
		rel.valid = load & last;
		rel.bank  = job.bank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_q      <= 1'b0;
			rd_cnt_q    <= '0;
			rd_v_s1     <= 1'b0;
			blk_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			rd_v_s1 <= rd_en;
			if (state_q == ST_PAL) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + POS_W'(1);
			end
			if (load) begin
				chan_q      <= ~last;
				blk_valid_q <= 1'b1;
			end else if (~block_stall) begin
				blk_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PAL) begin
			pal_q <= pal_n;
			hi_q  <= hi_n;
			lo_q  <= lo_n;
		end
		if (rd_v_s1) begin
			acc_q <= {best, acc_q[47:3]};
		end
		if (load) begin
			blk_q.endpoint_high <= hi_q;
			blk_q.endpoint_low  <= lo_q;
			blk_q.index_bits    <= acc_q;
			blk_q.channel_tag   <= chan_q;
			blk_q.last_of_block <= last;
		end
	end

	assign block_valid = blk_valid_q;
	assign block       = blk_q;

endmodule

// ===== rtl/bc4_bc5_block_encoder_top.sv =====
// Channel   Handshake                         Beat
// texel     texel_valid / texel_stall          texel (red, green byte)
// block     block_valid / block_stall          block (one encoded channel)
// config    psel penable pwrite pready paddr   pwdata / prdata, mode at 0
//
// Texels load one a cycle while texel_stall is low; a block of 16 goes into
// one of two store banks. Encoding steps through palette, 16 store reads,
// drain and output per channel, then idle per block; BC5 encodes red, then green.
// texel_stall rises while the bank to fill still waits; block_stall holds output.
// Reset clears counters, queue and mode; store contents are not cleared.
module bc4_bc5_block_encoder_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            texel_valid,
	output logic            texel_stall,
	input  bce_pkg::texel_t texel,
	output logic            block_valid,
	input  logic            block_stall,
	output bce_pkg::block_t block,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import bce_pkg::*;

	logic mode_q;
	logic push, pop, fifo_full, fifo_not_empty;
	job_t push_data, head;
	wr_t  wr;
	rel_t rel;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel & penable & pwrite & (paddr[2] == REG_MODE)) begin
			mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

	bce_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.texel_valid    (texel_valid),
		.texel_stall    (texel_stall),
		.texel          (texel),
		.mode           (mode_q),
		.fifo_full      (fifo_full),
		.fifo_not_empty (fifo_not_empty),
		.rel            (rel),
		.push           (push),
		.push_data      (push_data),
		.wr             (wr)
	);

	bce_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (fifo_full),
		.not_empty (fifo_not_empty),
		.head      (head)
	);

	bce_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.job_valid   (fifo_not_empty),
		.job         (head),
		.pop         (pop),
		.rel         (rel),
		.block_valid (block_valid),
		.block_stall (block_stall),
		.block       (block)
	);

endmodule

// ===== tb/bc4_bc5_block_checker.sv =====
module bc4_bc5_block_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            texel_valid,
	input  logic            texel_stall,
	input  bce_pkg::texel_t texel,
	input  logic            block_valid,
	input  logic            block_stall,
	input  bce_pkg::block_t block,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	input  logic [31:0]     prdata,
	input  logic            pready,
	output int              fault_count,
	output int              pending
);
	import bce_pkg::*;

	localparam logic [2:0] MODE_ADDR = 3'(4 * REG_MODE);

	typedef logic [7:0] lane_t [16];

	lane_t      red_held;
	lane_t      green_held;
	logic [3:0] fill;
	logic [7:0] red_lo, red_hi, green_lo, green_hi;
	logic       bc5;
	block_t     expected_blocks [$];

	function automatic logic [47:0] nearest_codes(input lane_t s, input logic [7:0] hi,
			input logic [7:0] lo);
		int pal [8];
		int h, l, sv, diff, best, best_diff;
		logic [47:0] codes;
		h = hi;
		l = lo;
		codes = '0;
		pal[0] = h;
		pal[1] = l;
		if (h > l) begin
			for (int k = 1; k <= 6; k++)
				pal[k + 1] = ((7 - k) * h + k * l) / 7;
		end else begin
			for (int k = 1; k <= 4; k++)
				pal[k + 1] = ((5 - k) * h + k * l) / 5;
			pal[6] = 0;
			pal[7] = 255;
		end
		foreach (s[t]) begin
			sv = s[t];
			best = 0;
			best_diff = 1000;
			for (int p = 0; p < 8; p++) begin
				diff = sv > pal[p] ? sv - pal[p] : pal[p] - sv;
				if (diff < best_diff) begin
					best = p;
					best_diff = diff;
				end
			end
			codes[3 * t +: 3] = 3'(best);
		end
		return codes;
	endfunction

	function automatic block_t encode_channel(input lane_t s, input logic [7:0] hi,
			input logic [7:0] lo, input logic tag, input logic last);
		block_t b;
		b.endpoint_high = hi;
		b.endpoint_low  = lo;
		b.index_bits    = nearest_codes(s, hi, lo);
		b.channel_tag   = tag;
		b.last_of_block = last;
		return b;
	endfunction

	function automatic void queue_block(input block_t b);
		expected_blocks = {expected_blocks, b};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		block_t want;
		if (!arst_n) begin
			fill = '0;
			red_lo = 8'd255;
			red_hi = 8'd0;
			green_lo = 8'd255;
			green_hi = 8'd0;
			bc5 = 1'b0;
			expected_blocks.delete();
			pending = 0;
		end else begin
			// results first: a beat taken at this edge cannot come from a texel taken here
			if (block_valid && !block_stall) begin
				if (expected_blocks.size() == 0) begin
					$error("block beat with nothing expected: %h", block);
					fault_count++;
				end else begin
					want = expected_blocks.pop_front();
					if (block.endpoint_high !== want.endpoint_high) begin
						$error("endpoint_high: expected %0d, got %0d",
							want.endpoint_high, block.endpoint_high);
						fault_count++;
					end
					if (block.endpoint_low !== want.endpoint_low) begin
						$error("endpoint_low: expected %0d, got %0d",
							want.endpoint_low, block.endpoint_low);
						fault_count++;
					end
					if (block.index_bits !== want.index_bits) begin
						$error("index_bits: expected %h, got %h",
							want.index_bits, block.index_bits);
						fault_count++;
					end
					if (block.channel_tag !== want.channel_tag) begin
						$error("channel_tag: expected %0d, got %0d",
							want.channel_tag, block.channel_tag);
						fault_count++;
					end
					if (block.last_of_block !== want.last_of_block) begin
						$error("last_of_block: expected %0d, got %0d",
							want.last_of_block, block.last_of_block);
						fault_count++;
					end
				end
			end
			if (texel_valid && !texel_stall) begin
				red_held[fill] = texel.red_sample;
				green_held[fill] = texel.green_sample;
				if (texel.red_sample < red_lo) red_lo = texel.red_sample;
				if (texel.red_sample > red_hi) red_hi = texel.red_sample;
				if (texel.green_sample < green_lo) green_lo = texel.green_sample;
				if (texel.green_sample > green_hi) green_hi = texel.green_sample;
				if (fill == 4'd15) begin
					// mode taken as it stands on the closing texel
					queue_block(encode_channel(red_held, red_hi, red_lo, 1'b0, !bc5));
					if (bc5)
						queue_block(encode_channel(green_held, green_hi, green_lo,
							1'b1, 1'b1));
					red_lo = 8'd255;
					red_hi = 8'd0;
					green_lo = 8'd255;
					green_hi = 8'd0;
				end
				fill = fill + 4'd1;
			end
			if (psel && penable && pready && paddr == MODE_ADDR) begin
				if (pwrite) begin
					bc5 = pwdata[0];
				end else if (prdata !== {31'b0, bc5}) begin
					$error("mode: expected %0d, got %0d", bc5, prdata);
					fault_count++;
				end
			end
			pending = expected_blocks.size();
		end
	end

endmodule

// ===== tb/bc4_bc5_block_encoder_top_test.sv =====
module bc4_bc5_block_encoder_top_test;
	import bce_pkg::*;

	localparam logic [2:0] MODE_ADDR  = 3'(4 * REG_MODE);
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;

	typedef logic [7:0] lane_t [16];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        texel_valid = 1'b0;
	logic        texel_stall;
	texel_t      texel = '0;
	logic        block_valid;
	logic        block_stall = 1'b0;
	block_t      block;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fault_count;
	int          pending;

	bit gaps_on = 1'b1;
	int stall_hold = 0;
	int stall_free = 0;
	int quiet = 0;

	bc4_bc5_block_encoder_top dut (.*);

	bc4_bc5_block_checker u_check (.*);

	always #6 clk = ~clk;

	// receiver: short stalls mostly, the odd long one, and stall-free stretches
	always @(posedge clk) begin
		int pick;
		if (stall_hold > 0) begin
			block_stall <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else if (stall_free > 0) begin
			block_stall <= 1'b0;
			stall_free <= stall_free - 1;
		end else begin
			pick = $urandom_range(0, 99);
			block_stall <= pick < 40;
			if (pick < 3)
				stall_hold <= $urandom_range(20, 60);
			else if (pick < 40)
				stall_hold <= $urandom_range(0, 3);
			else if (pick < 48)
				stall_free <= $urandom_range(30, 150);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (texel_valid && !texel_stall) || (block_valid && !block_stall) ||
				(psel && penable)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic int next_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (!gaps_on || pick < 55)
			return 0;
		if (pick < 88)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic lane_t random_lane();
		lane_t v;
		int shape, base, other, span, tmp;
		shape = $urandom_range(0, 9);
		base = $urandom_range(0, 255);
		other = $urandom_range(0, 255);
		span = $urandom_range(1, 12);
		foreach (v[i]) begin
			tmp = $urandom_range(0, 255);
			case (shape)
				3: tmp = base;
				4, 5: tmp = base + $urandom_range(0, span);
				6: tmp = $urandom_range(0, 1) ? base : other;
				7: tmp = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 255 : tmp);
				8: tmp = base < 128 ? 0 : 255;
				9: tmp = i == (other % 16) ? other : base;
				default: ;
			endcase
			v[i] = tmp > 255 ? 8'd255 : 8'(tmp);
		end
		return v;
	endfunction

	task automatic push_texel(input logic [7:0] r, input logic [7:0] g);
		int gap;
		texel_valid <= 1'b1;
		texel <= '{red_sample: r, green_sample: g};
		@(posedge clk);
		while (texel_stall)
			@(posedge clk);
		gap = next_gap();
		if (gap > 0) begin
			texel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic push_texels(input lane_t r, input lane_t g, input int first,
			input int count);
		for (int i = first; i < first + count; i++)
			push_texel(r[i], g[i]);
	endtask

	// let every expected block drain, then some margin for a partly filled bank
	task automatic settle();
		texel_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [2:0] a);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		lane_t red_lane, green_lane;
		logic [31:0] word;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// BC4 after reset: red hits both rails and palette boundaries, green flat and unused
		red_lane = '{8'd0, 8'd255, 8'd36, 8'd37, 8'd72, 8'd73, 8'd109, 8'd110,
			8'd145, 8'd146, 8'd182, 8'd183, 8'd218, 8'd219, 8'd128, 8'd127};
		green_lane = '{default: 8'd200};
		push_texels(red_lane, green_lane, 0, 16);
		settle();
		reg_read(MODE_ADDR);
		reg_write(SPARE_ADDR, 32'hFFFF_FFFF);
		reg_read(MODE_ADDR);

		// flat red; mode switched to BC5 halfway through the block
		red_lane = '{default: 8'd77};
		green_lane = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd85, 8'd170, 8'd51, 8'd204,
			8'd1, 8'd254, 8'd128, 8'd127, 8'd64, 8'd191, 8'd15, 8'd240};
		push_texels(red_lane, green_lane, 0, 8);
		settle();
		reg_write(MODE_ADDR, 32'hFFFF_FFFF);
		reg_write(SPARE_ADDR, 32'h0000_0000);
		reg_read(MODE_ADDR);
		push_texels(red_lane, green_lane, 8, 8);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			word = $urandom();
			word[0] = phase % 3 != 0;
			reg_write(MODE_ADDR, word);
			reg_read(MODE_ADDR);
			gaps_on = !(phase == 2 || phase == 5);
			for (int b = 0; b < 12; b++) begin
				red_lane = random_lane();
				green_lane = random_lane();
				push_texels(red_lane, green_lane, 0, 16);
			end
			settle();
		end

		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bce_pkg.sv
rtl/bce_fifo.sv
rtl/bce_front.sv
rtl/bce_back.sv
rtl/bc4_bc5_block_encoder_top.sv
tb/bc4_bc5_block_checker.sv
tb/bc4_bc5_block_encoder_top_test.sv
